### design/cfr_pkg.sv
// Shared constants, widths, state encoding and control structs for the
// continued-fraction ratio unit. No dependencies.
package cfr_pkg;

  // Expansion limits
  localparam int MAX_TERMS = 15;
  localparam int FRAC_BITS = 32;

  // Field widths
  localparam int IN_W  = 48;
  localparam int LIM_W = 16;

  // Reciprocal of a fraction past the precision test is below 2^(2*FRAC_BITS-16)
  localparam int X_W    = (2 * FRAC_BITS - LIM_W > IN_W) ? 2 * FRAC_BITS - LIM_W : IN_W;
  localparam int A_W    = X_W - FRAC_BITS;
  localparam int PROD_W = A_W + LIM_W;
  localparam int SUM_W  = PROD_W + 1;

  // Restoring division of 2^(2*FRAC_BITS) by the fraction
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Term counter
  localparam int TERMS  = MAX_TERMS - 2;
  localparam int TERM_W = $clog2(MAX_TERMS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } cfr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take a new word, reset convergents
    logic mul;        // register a*p1 and a*q1
    logic upd;        // shift convergents
    logic set_exact;  // record precision stop
    logic div_start;  // clear divider
    logic div_step;   // one restoring division step
    logic load_out;   // move convergent into output register
  } cfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ovf;        // new p or q exceeds 16 bits
    logic prec;       // fraction below 1/65535
    logic div_last;   // final division step
    logic out_free;   // output register can take a word
  } cfr_status_t;

endpackage

### design/cfr_sample_if.sv
// Input channel: valid/ready handshake carrying the Q16.32 value.
// Depends on cfr_pkg.
interface cfr_sample_if;
  logic                     valid;
  logic                     ready;
  logic [cfr_pkg::IN_W-1:0] value_x;

  modport source (output valid, output value_x, input ready);
  modport sink (input valid, input value_x, output ready);
endinterface

### design/cfr_result_if.sv
// Output channel: valid/ready handshake carrying the chosen convergent.
// Depends on cfr_pkg.
interface cfr_result_if;
  logic                      valid;
  logic                      ready;
  logic [cfr_pkg::LIM_W-1:0] numerator;
  logic [cfr_pkg::LIM_W-1:0] denominator;
  logic                      exact_stop;

  modport source (output valid, output numerator, output denominator,
                  output exact_stop, input ready);
  modport sink (input valid, input numerator, input denominator,
                input exact_stop, output ready);
endinterface

### design/continued_fraction_ratio_unit.sv
// Continued-fraction ratio unit: best 16-bit p/q for an unsigned Q16.32 word.
// Each term runs a multiply, a check and a 65-step bit-serial reciprocal divider;
// the last term skips the divide. One item is worked at a time, and the next is taken
// while the finished word waits. Synchronous rst idles the controller, empties output.
// Depends on cfr_pkg, cfr_sample_if, cfr_result_if, cfr_ctrl, cfr_datapath.
module continued_fraction_ratio_unit (
  input logic          clk,
  input logic          rst,
  cfr_sample_if.sink   sample,
  cfr_result_if.source result
);

  cfr_pkg::cfr_cmd_t    cmd;
  cfr_pkg::cfr_status_t status;
  logic                 in_ready;

  assign sample.ready = in_ready;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value_x     (sample.value_x),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .numerator   (result.numerator),
    .denominator (result.denominator),
    .exact_stop  (result.exact_stop)
  );

  // A precision stop always follows at least one accepted term
  a_exact_den: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.exact_stop |-> result.denominator != '0)
    else $error("exact word with zero denominator");

  // The divider hands back to the multiplier after its last step
  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && status.div_last |=> cmd.mul)
    else $error("term did not resume after division");

  // Phase commands never overlap
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.div_start, cmd.div_step, cmd.load_out}))
    else $error("overlapping phase commands");

  // A loaded result is presented on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("result word not presented");

endmodule

### design/cfr_datapath.sv
// Datapath: value register, convergent recurrences, bit-serial reciprocal
// divider and output register. Depends on cfr_pkg.
module cfr_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  cfr_pkg::cfr_cmd_t         cmd,
  output cfr_pkg::cfr_status_t      status,
  input  logic [cfr_pkg::IN_W-1:0]  value_x,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [cfr_pkg::LIM_W-1:0] numerator,
  output logic [cfr_pkg::LIM_W-1:0] denominator,
  output logic                      exact_stop
);

  localparam int F = cfr_pkg::FRAC_BITS;
  localparam int L = cfr_pkg::LIM_W;

  logic [cfr_pkg::X_W-1:0]    x;
  logic [cfr_pkg::A_W-1:0]    a;
  logic [F-1:0]               f;
  logic [L-1:0]               p0, q0, p1, q1;
  logic [cfr_pkg::PROD_W-1:0] prod_p, prod_q;
  logic [cfr_pkg::SUM_W-1:0]  p_sum, q_sum;
  logic [F+L-1:0]             f_scaled;
  logic                       exact;

  logic [F-1:0]               rem;
  logic [F:0]                 rem_sh;
  logic                       rem_ge;
  logic [F-1:0]               rem_next;
  logic [cfr_pkg::X_W-1:0]    quot, quot_next;
  logic [cfr_pkg::DCNT_W-1:0] dcnt;

  assign a = x[cfr_pkg::X_W-1:F];
  assign f = x[F-1:0];

  // Recurrence sums and stop tests
  assign p_sum    = cfr_pkg::SUM_W'(prod_p) + cfr_pkg::SUM_W'(p0);
  assign q_sum    = cfr_pkg::SUM_W'(prod_q) + cfr_pkg::SUM_W'(q0);
  assign f_scaled = {f, L'(0)} - (F+L)'(f);  // f * 65535

  assign status.ovf      = (p_sum[cfr_pkg::SUM_W-1:L] != '0) ||
                           (q_sum[cfr_pkg::SUM_W-1:L] != '0);
  assign status.prec     = (f_scaled[F+L-1:F] == '0);
  assign status.div_last = (dcnt == cfr_pkg::DCNT_W'(cfr_pkg::DIV_STEPS - 1));
  assign status.out_free = !res_valid || res_ready;

  // Restoring division step; dividend is a single one followed by zeros
  assign rem_sh    = {rem, (dcnt == '0)};
  assign rem_ge    = (rem_sh >= {1'b0, f});
  assign rem_next  = rem_ge ? F'(rem_sh - {1'b0, f}) : rem_sh[F-1:0];
  assign quot_next = {quot[cfr_pkg::X_W-2:0], rem_ge};

  // Value and convergents
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= cfr_pkg::X_W'(value_x);
      p0    <= '0;
      q0    <= L'(1);
      p1    <= L'(1);
      q1    <= '0;
      exact <= 1'b0;
    end else begin
      if (cmd.upd) begin
        p0 <= p1;
        q0 <= q1;
        p1 <= p_sum[L-1:0];
        q1 <= q_sum[L-1:0];
      end
      if (cmd.set_exact) begin
        exact <= 1'b1;
      end
      if (cmd.div_step && status.div_last) begin
        x <= quot_next;
      end
    end
  end

  // Products of the term with the last convergent
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_p <= cfr_pkg::PROD_W'(a) * cfr_pkg::PROD_W'(p1);
      prod_q <= cfr_pkg::PROD_W'(a) * cfr_pkg::PROD_W'(q1);
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= '0;
      quot <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      quot <= quot_next;
      dcnt <= dcnt + cfr_pkg::DCNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      numerator   <= p1;
      denominator <= q1;
      exact_stop  <= exact;
    end
  end

endmodule

### design/cfr_ctrl.sv
// Controller: sequences multiply, check and divide phases for each term.
// Depends on cfr_pkg.
module cfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfr_pkg::cfr_status_t status,
  output cfr_pkg::cfr_cmd_t    cmd
);

  cfr_pkg::cfr_state_t        state, state_next;
  logic [cfr_pkg::TERM_W-1:0] term, term_next;
  logic                       last_term;

  assign last_term = (term == cfr_pkg::TERM_W'(cfr_pkg::TERMS - 1));

  // State and term count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfr_pkg::ST_IDLE;
      term  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      cfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          term_next  = '0;
          state_next = cfr_pkg::ST_MUL;
        end
      end
      cfr_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = cfr_pkg::ST_CHK;
      end
      cfr_pkg::ST_CHK: begin
        if (status.ovf) begin
          state_next = cfr_pkg::ST_FIN;
        end else begin
          cmd.upd = 1'b1;
          if (status.prec) begin
            cmd.set_exact = 1'b1;
            state_next    = cfr_pkg::ST_FIN;
          end else if (last_term) begin
            state_next = cfr_pkg::ST_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = cfr_pkg::ST_DIV;
          end
        end
      end
      cfr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          term_next  = term + cfr_pkg::TERM_W'(1);
          state_next = cfr_pkg::ST_MUL;
        end
      end
      cfr_pkg::ST_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = cfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sim/continued_fraction_ratio_unit_test.sv
// Self-checking testbench for continued_fraction_ratio_unit: drives Q16.32 words,
// predicts each 16-bit convergent and checks it. Depends on cfr_pkg,
// cfr_sample_if, cfr_result_if and the unit itself.
`timescale 1ns / 1ps

module continued_fraction_ratio_unit_test;

  localparam int DRAIN_CYCLES   = 1000;   // a little over the slowest word
  localparam int WATCHDOG_LIMIT = 20000;  // covers the long hold-off plus a full word
  localparam int HOLD_CYCLES    = 3000;
  localparam int RANDOM_WORDS   = 640;

  localparam logic [127:0] RATIO_MAX = (128'd1 << cfr_pkg::LIM_W) - 128'd1;
  localparam logic [127:0] FIX_ONE   = 128'd1 << cfr_pkg::FRAC_BITS;

  typedef struct packed {
    logic [cfr_pkg::LIM_W-1:0] numerator;
    logic [cfr_pkg::LIM_W-1:0] denominator;
    logic                      exact_stop;
  } ratio_t;

  typedef struct {
    logic [cfr_pkg::IN_W-1:0] word;
    ratio_t                   ratio;
  } ratio_entry_t;

  logic clk;
  logic rst;

  cfr_sample_if sample_ch ();
  cfr_result_if result_ch ();

  continued_fraction_ratio_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  logic [cfr_pkg::IN_W-1:0] stim_words[$];
  ratio_entry_t             expected_ratios[$];

  int   mismatches;
  int   words_taken;
  int   results_seen;
  int   exact_count;
  int   zero_den_count;
  int   idle_cycles;
  logic in_taken;

  // sender state
  int   burst_left;
  int   gap_left;
  logic next_valid;

  // receiver state
  int   hold_left;
  logic hold_done;
  int   mode;
  int   mode_left;
  int   stall_left;
  logic next_ready;

  ratio_entry_t want;
  ratio_t       got;

  always #5 clk = ~clk;

  // Expand the word as a continued fraction, keeping the last convergent that fits
  function automatic ratio_t best_ratio(input logic [cfr_pkg::IN_W-1:0] word);
    logic [127:0] x, a, f, p, q, p_prev, q_prev, p_cur, q_cur;
    ratio_t r;
    int term;
    x = word;
    p_prev = 0;
    q_prev = 1;
    p_cur = 1;
    q_cur = 0;
    r.exact_stop = 1'b0;
    for (term = 2; term < cfr_pkg::MAX_TERMS; term++) begin
      a = x >> cfr_pkg::FRAC_BITS;
      f = x & (FIX_ONE - 128'd1);
      p = a * p_cur + p_prev;
      q = a * q_cur + q_prev;
      if (p > RATIO_MAX || q > RATIO_MAX) break;
      p_prev = p_cur;
      q_prev = q_cur;
      p_cur = p;
      q_cur = q;
      // fraction below 1/65535: current convergent is final
      if (f * RATIO_MAX < FIX_ONE) begin
        r.exact_stop = 1'b1;
        break;
      end
      x = (128'd1 << (2 * cfr_pkg::FRAC_BITS)) / f;
    end
    r.numerator = p_cur[cfr_pkg::LIM_W-1:0];
    r.denominator = q_cur[cfr_pkg::LIM_W-1:0];
    return r;
  endfunction

  // Rounded fixed-point encoding of p/q
  function automatic logic [cfr_pkg::IN_W-1:0] ratio_word(input longint unsigned p,
                                                          input longint unsigned q);
    longint unsigned v;
    v = ((p << cfr_pkg::FRAC_BITS) + q / 2) / q;
    return v[cfr_pkg::IN_W-1:0];
  endfunction

  function automatic logic [cfr_pkg::IN_W-1:0] random_word();
    logic [63:0] raw;
    longint unsigned q, k, off;
    int kind;
    raw = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // small-denominator ratios, which can end on the precision test
      q = $urandom_range(1, 300);
      return ratio_word($urandom_range(0, 300) * q + $urandom_range(0, q - 1), q);
    end else if (kind < 60) begin
      q = $urandom_range(1, 65535);
      return ratio_word($urandom_range(0, 65535), q);
    end else if (kind < 80) begin
      return raw[cfr_pkg::IN_W-1:0];
    end else if (kind < 90) begin
      // fraction only, sometimes near the threshold
      if (raw[63]) return cfr_pkg::IN_W'(raw[31:0]);
      return cfr_pkg::IN_W'($urandom_range(0, 200000));
    end else begin
      // near an integer, either side
      k = $urandom_range(1, 65535);
      off = $urandom_range(0, 131072);
      if (raw[62]) return cfr_pkg::IN_W'((k << cfr_pkg::FRAC_BITS) + off);
      return cfr_pkg::IN_W'((k << cfr_pkg::FRAC_BITS) - off);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 20);
    if (r < 97) return $urandom_range(21, 200);
    return $urandom_range(300, 1200);
  endfunction

  // Append a word to the stimulus queue
  task automatic queue_stim(input logic [cfr_pkg::IN_W-1:0] w);
    stim_words.insert(stim_words.size(), w);
  endtask

  task automatic report_mismatch(input string what, input logic [cfr_pkg::IN_W-1:0] word,
                                 input int got_val, input int want_val);
    $display("[%0t] mismatch %s for x=%012h: got %0d, expected %0d",
             $realtime, what, word, got_val, want_val);
    mismatches++;
  endtask

  // Accept, predict and check at the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && sample_ch.valid && sample_ch.ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.numerator = result_ch.numerator;
      got.denominator = result_ch.denominator;
      got.exact_stop = result_ch.exact_stop;
      results_seen++;
      if (got.exact_stop) exact_count++;
      if (got.denominator == '0) zero_den_count++;
      if (expected_ratios.size() == 0) begin
        report_mismatch("unexpected word", '0, got.numerator, -1);
      end else begin
        want = expected_ratios.pop_front();
        if (got.numerator !== want.ratio.numerator)
          report_mismatch("numerator", want.word, got.numerator, want.ratio.numerator);
        if (got.denominator !== want.ratio.denominator)
          report_mismatch("denominator", want.word, got.denominator,
                          want.ratio.denominator);
        if (got.exact_stop !== want.ratio.exact_stop)
          report_mismatch("exact_stop", want.word, got.exact_stop, want.ratio.exact_stop);
      end
    end
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      want.word = sample_ch.value_x;
      want.ratio = best_ratio(sample_ch.value_x);
      expected_ratios.insert(expected_ratios.size(), want);
      words_taken++;
    end
  end

  // Sender: bursts of words with random gaps; a word holds until taken
  always @(negedge clk) begin
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_taken) begin
        void'(stim_words.pop_front());
        burst_left--;
      end
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = pick_gap();
      end
      if (sample_ch.valid && !in_taken) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else begin
        next_valid = stim_words.size() > 0;
      end
    end
    sample_ch.valid <= next_valid;
    if (next_valid) sample_ch.value_x <= stim_words[0];
  end

  // Receiver: one long hold-off, otherwise modes of steady, random and run stalls
  always @(negedge clk) begin
    if (rst) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      next_ready = 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(500, 4000);
      end
      mode_left--;
      case (mode)
        0: begin
          next_ready = 1'b1;
        end
        1: begin
          next_ready = $urandom_range(0, 1);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 900);
          end
        end
      endcase
    end
    result_ch.ready <= next_ready;
  end

  // Watchdog on cycles with no input word taken and no expected word returned
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready && expected_ratios.size() != 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
      $display("continued_fraction_ratio_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.value_x = '0;
    result_ch.ready = 1'b0;
    in_taken = 1'b0;
    mismatches = 0;
    words_taken = 0;
    results_seen = 0;
    exact_count = 0;
    zero_den_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode = 0;
    mode_left = 0;
    stall_left = 0;

    // Directed words: extremes, threshold edges, known expansions
    queue_stim('0);                              // zero -> 0/1 exact
    queue_stim({cfr_pkg::IN_W{1'b1}});           // largest word
    queue_stim(48'h0001_0000_0000);              // 1.0
    queue_stim(48'hFFFF_0000_0000);              // 65535.0
    queue_stim(48'h8000_0000_0000);              // 32768.0
    queue_stim(48'hFFFF_0000_0001);              // just above 65535
    queue_stim(48'h0000_0000_0001);              // smallest nonzero
    queue_stim(48'h0000_0001_0001);              // fraction right at the threshold
    queue_stim(48'h0000_0001_0002);              // first fraction past it
    queue_stim(48'h0000_8000_0000);              // 1/2
    queue_stim(48'h0000_5555_5555);              // 1/3
    queue_stim(48'h0000_AAAA_AAAB);              // 2/3
    queue_stim(48'h0000_FFFF_FFFF);              // just below 1
    queue_stim(48'h0001_0000_0001);              // just above 1
    queue_stim(48'h0003_243F_6A88);              // pi, overflow stop
    queue_stim(48'h0001_9E37_79B9);              // golden ratio, term limit
    queue_stim(48'h0001_6A09_E667);              // sqrt 2
    queue_stim(48'h0002_B7E1_5162);              // e
    queue_stim(ratio_word(12345, 54321));
    queue_stim(ratio_word(65535, 65534));
    queue_stim(ratio_word(1, 65535));
    queue_stim(ratio_word(65535, 1));
    for (int i = 0; i < RANDOM_WORDS; i++) queue_stim(random_word());

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (stim_words.size() == 0);
    wait (expected_ratios.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d precision stops, %0d overflow or term-limit stops",
             words_taken, exact_count, results_seen - exact_count);
    $display("%0d results with zero denominator; receiver held off %0d cycles once",
             zero_den_count, HOLD_CYCLES);
    if (mismatches == 0 && expected_ratios.size() == 0)
      $display("continued_fraction_ratio_unit_test: PASS");
    else
      $display("continued_fraction_ratio_unit_test: FAIL");
    $finish;
  end

endmodule
